// ===== rtl/ps2mc_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor package
// Shared widths, flag bit positions, item and result types for the PS/2
// mouse packet decoder with a clamped cursor.
// ----------------------------------------------------------------------------
package ps2mc_pkg;

    localparam int COORD_BITS    = 12;
    localparam int CURSOR_MARGIN = 16;
    localparam int SIZE_BITS     = 13;
    localparam int BYTE_BITS     = 8;
    localparam int CFG_IDX_BITS  = 2;

    // Width that holds a clamp limit before it is saturated to the coordinate range.
    localparam int LIM_W = ((SIZE_BITS > COORD_BITS) ? SIZE_BITS : COORD_BITS) + 1;
    // Width that holds a coordinate plus or minus one signed byte.
    localparam int SUM_W = COORD_BITS + 2;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(1024);
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(768);

    // Bit positions inside the first packet byte.
    localparam int FLAG_ALWAYS_ONE = 3;
    localparam int FLAG_X_OVF      = 6;
    localparam int FLAG_Y_OVF      = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

    // Input command codes.
    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [SIZE_BITS-1:0]  size_t;
    typedef logic [BYTE_BITS-1:0]  byte_t;

    typedef enum logic [2:0] {
        PH_FLAGS = 3'b001,
        PH_DX    = 3'b010,
        PH_DY    = 3'b100
    } phase_t;

    typedef struct packed {
        logic  command;
        logic  from_aux;
        byte_t data_byte;
    } item_t;

    typedef struct packed {
        coord_t cursor_y;
        coord_t cursor_x;
        byte_t  button_flags;
    } result_t;

    typedef struct packed {
        logic emit;
        logic event_pending;
    } dec_status_t;

endpackage

// ===== rtl/ps2_mouse_packet_cursor_unit.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor unit
// Assembles three-byte PS/2 mouse packets into a clamped cursor position and
// returns the button flags and position once per pending event.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_        in         tdata = data_byte; tuser = command, from_aux
// m_        out        tdata = button_flags, cursor_x, cursor_y; tuser = event_ready
// cfg_      in         cfg_index selects screen_width (0) or screen_height (1)
//
// Every input transaction is registered, then processed against the decoder
// state once the output register is free or being drained, so one transaction
// is taken per clock while the output is not stalled; a read result passes
// through the input register and then the output register.
// Reset is synchronous and active low; after it the screen is 1024 by 768,
// the cursor sits at the origin and one event is already pending.
// A stalled result holds in the output register; the input register keeps
// accepting until it holds an item that cannot move on.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_unit
    import ps2mc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] data_byte
    input  logic [1:0]              s_tuser,   // [0] command, [1] from_aux

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,   // [7:0] button_flags, [19:8] cursor_x,
                                               // [31:20] cursor_y
    output logic                    m_tuser,   // [0] event_ready

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]    cfg_data
);

    // Input register: holds the last accepted transaction until the decoder
    // has processed it.
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;

    // Output register: holds a finished result until the sink takes it.
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    size_t   width_reg;
    size_t   height_reg;

    logic        proc_fire;
    dec_status_t dec_status;
    result_t     dec_result;

    // The decoder only consumes an item when the output register is free or
    // being drained, so a read command can always place its result.
    assign proc_fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready      = !in_valid_reg || proc_fire;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_comb begin
        if (dec_status.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    ps2mc_decoder u_decoder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (proc_fire),
        .item         (in_item_reg),
        .screen_width (width_reg),
        .screen_height(height_reg),
        .status       (dec_status),
        .result       (dec_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.command   <= s_tuser[0];
            in_item_reg.from_aux  <= s_tuser[1];
            in_item_reg.data_byte <= s_tdata;
        end
        if (dec_status.emit) begin
            out_data_reg <= dec_result;
        end
    end

    // Configuration writes are always taken; an unknown index is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_SCREEN_WIDTH) begin
                width_reg <= cfg_data;
            end else if (cfg_index == CFG_SCREEN_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = 1'b1;

`ifndef SYNTHESIS
    // The input side only stalls while a transaction is waiting inside.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with an empty input register");

    // An item processed without a result leaves the output register empty.
    a_no_stray_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && !dec_status.emit) |=> !m_tvalid)
        else $error("result appeared for an item that gives none");

    // A returned event is no longer pending.
    a_event_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_status.emit |=> (m_tvalid && !dec_status.event_pending))
        else $error("event still pending after it was returned");

    // A result is only produced for a read of a pending event.
    a_emit_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_status.emit |-> (proc_fire && in_item_reg.command == CMD_READ
                             && dec_status.event_pending))
        else $error("result produced without a pending read");
`endif

endmodule

// ===== rtl/ps2mc_axis_step.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor axis step
// Applies one signed 8-bit delta, negated if asked, to a coordinate and clamps
// the result to the range from 0 to the screen size minus the cursor margin, capped at the coordinate maximum.
// ----------------------------------------------------------------------------
module ps2mc_axis_step
    import ps2mc_pkg::*;
(
    input  coord_t pos,
    input  byte_t  delta,
    input  logic   negate,
    input  size_t  screen_size,
    output coord_t pos_next
);

    logic [LIM_W-1:0]        lim_wide;
    coord_t                  lim;
    logic signed [SUM_W-1:0] step;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lim_s;

    always_comb begin
        if (LIM_W'(screen_size) < LIM_W'(CURSOR_MARGIN)) begin
            lim_wide = '0;
        end else begin
            lim_wide = LIM_W'(screen_size) - LIM_W'(CURSOR_MARGIN);
        end
        if (lim_wide > LIM_W'(COORD_MAX)) begin
            lim = COORD_MAX;
        end else begin
            lim = lim_wide[COORD_BITS-1:0];
        end
    end

    always_comb begin
        step  = SUM_W'($signed(delta));
        if (negate) begin
            step = -step;
        end
        sum   = $signed(SUM_W'(pos)) + step;
        lim_s = $signed(SUM_W'(lim));
        if (sum < 0) begin
            pos_next = '0;
        end else if (sum > lim_s) begin
            pos_next = lim;
        end else begin
            pos_next = sum[COORD_BITS-1:0];
        end
    end

endmodule

// ===== rtl/ps2mc_decoder.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor packet decoder
// Holds the packet phase, latched flags and delta, cursor position and the
// pending event flag, and updates them for one item per cycle while fire is high.
// ----------------------------------------------------------------------------
module ps2mc_decoder
    import ps2mc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  item_t       item,
    input  size_t       screen_width,
    input  size_t       screen_height,
    output dec_status_t status,
    output result_t     result
);

    phase_t phase_reg, phase_next;
    byte_t  flags_reg, flags_next;
    byte_t  dx_reg, dx_next;
    coord_t pos_x_reg, pos_x_next;
    coord_t pos_y_reg, pos_y_next;
    logic   pending_reg, pending_next;

    coord_t x_step;
    coord_t y_step;

    ps2mc_axis_step u_step_x (
        .pos        (pos_x_reg),
        .delta      (dx_reg),
        .negate     (1'b0),
        .screen_size(screen_width),
        .pos_next   (x_step)
    );

    ps2mc_axis_step u_step_y (
        .pos        (pos_y_reg),
        .delta      (item.data_byte),
        .negate     (1'b1),
        .screen_size(screen_height),
        .pos_next   (y_step)
    );

    always_comb begin
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        dx_next      = dx_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        pending_next = pending_reg;
        status.emit          = 1'b0;
        status.event_pending = pending_reg;
        if (fire) begin
            if (item.command == CMD_READ) begin
                if (pending_reg) begin
                    status.emit  = 1'b1;
                    pending_next = 1'b0;
                end
            end else if (item.from_aux) begin
                unique case (phase_reg)
                    PH_DX: begin
                        dx_next    = item.data_byte;
                        phase_next = PH_DY;
                    end
                    PH_DY: begin
                        phase_next = PH_FLAGS;
                        if (!flags_reg[FLAG_X_OVF] && !flags_reg[FLAG_Y_OVF]) begin
                            pos_x_next   = x_step;
                            pos_y_next   = y_step;
                            pending_next = 1'b1;
                        end
                    end
                    default: begin
                        flags_next = item.data_byte;
                        phase_next = item.data_byte[FLAG_ALWAYS_ONE] ? PH_DX : PH_FLAGS;
                    end
                endcase
            end
        end
    end

    assign result.button_flags  = flags_reg;
    assign result.cursor_x      = pos_x_reg;
    assign result.cursor_y      = pos_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FLAGS;
            flags_reg   <= '0;
            dx_reg      <= '0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pending_reg <= 1'b1;
        end else begin
            phase_reg   <= phase_next;
            flags_reg   <= flags_next;
            dx_reg      <= dx_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            pending_reg <= pending_next;
        end
    end

endmodule
